// ----- sv/ptom_pkg.sv -----
// Shared types and constants of the peer time offset median filter.
package ptom_pkg;
	localparam int unsigned SampleW = 32;
	localparam int unsigned LimitW = 31;
	localparam int unsigned FillW = 8;
	localparam int unsigned MedianMinCount = 5;
	localparam logic [LimitW-1:0] LimitReset = LimitW'(70 * 60);
	typedef logic signed [SampleW-1:0] sample_t;
endpackage

// ----- sv/peer_time_offset_median.sv -----
// Peer time offset median filter: sliding sample window held in one synchronous memory.
// An ignored request goes from S_IDLE straight to S_DONE, which raises m_tvalid; a taken
// request passes S_WRITE and S_CHECK first, and a due median adds an S_OUTER/S_INNER pass
// over the window for each candidate tried. One request at a time: s_tready stays low until
// the result has been taken. The count pass reads the window memory once a cycle.
// Reset clears all control state; the window memory needs no clearing because slot zero holds
// the seed in a register-backed flag and the other slots are written before they are read.
module peer_time_offset_median import ptom_pkg::*; #(
	parameter int unsigned WINDOW_SIZE = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // peer clock offset
	input  logic        s_tuser,  // source_is_new
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // sample_taken, offset_updated, adjusted_offset, window_fill, 6'b0
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data  // max_offset_limit
);
	localparam int unsigned AW = $clog2(WINDOW_SIZE);
	localparam logic [FillW-1:0] WinFull = FillW'(WINDOW_SIZE);

	typedef enum logic [2:0] {S_IDLE, S_WRITE, S_OUTER, S_INNER, S_CHECK, S_DONE} state_t;

	state_t state_q;
	sample_t mem [WINDOW_SIZE];
	sample_t rd_q, cand_q, sample_q, offset_q;
	logic seed_q; // slot zero still holds the seed
	logic [FillW-1:0] count_q, oldest_q, peers_q, i_q, j_q, lt_q, le_q;
	logic [LimitW-1:0] limit_q;
	logic taken_q, updated_q, new_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [AW-1:0] rd_addr_q;
	sample_t rd_val;
	logic [FillW-1:0] pos;
	logic [FillW:0] pos_w;
	logic [SampleW:0] mag;

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;
	assign cfg_ready = 1'b1;
	assign m_tdata = {6'b0, count_q, offset_q, updated_q, taken_q};

	// Physical slot of window position count_q (one past the newest entry), relative to the oldest entry.
	assign pos_w = {1'b0, oldest_q} + {1'b0, count_q};
	assign pos = (pos_w >= (FillW+1)'(WINDOW_SIZE)) ?
		FillW'(pos_w - (FillW+1)'(WINDOW_SIZE)) : FillW'(pos_w);
	assign wr_addr = (count_q >= WinFull) ? oldest_q[AW-1:0] : pos[AW-1:0];
	// During the compare cycles the read runs one slot ahead of j, so that the data of slot j
	// is ready in the cycle that compares it.
	assign rd_addr = (state_q == S_OUTER) ? i_q[AW-1:0] :
		(new_q ? j_q[AW-1:0] : j_q[AW-1:0] + AW'(1));
	assign rd_val = (seed_q && rd_addr_q == '0) ? '0 : rd_q;

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) mem[wr_addr] <= sample_q;
		rd_q <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	assign mag = cand_q[SampleW-1] ? -{cand_q[SampleW-1], cand_q} : {1'b0, cand_q};

	// i_q/j_q hold physical slot indexes; the occupied slots are all slots below count_q
	// until the window first fills, and all slots afterwards, so they scan 0..count-1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; m_tvalid <= 1'b0; seed_q <= 1'b1;
			count_q <= FillW'(1); oldest_q <= '0; peers_q <= '0; offset_q <= '0;
			limit_q <= LimitReset; taken_q <= 1'b0; updated_q <= 1'b0;
			i_q <= '0; j_q <= '0; lt_q <= '0; le_q <= '0; new_q <= 1'b0;
			cand_q <= '0; sample_q <= '0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					sample_q <= s_tdata; taken_q <= 1'b0; updated_q <= 1'b0;
					if (s_tuser && peers_q < WinFull) begin
						peers_q <= peers_q + 1'b1; taken_q <= 1'b1; state_q <= S_WRITE;
					end else state_q <= S_DONE;
				end
				S_WRITE: begin
					if (wr_addr == '0) seed_q <= 1'b0;
					if (count_q >= WinFull) begin
						oldest_q <= (oldest_q == WinFull - 1'b1) ? '0 : oldest_q + 1'b1;
						new_q <= WinFull[0];
					end else begin
						count_q <= count_q + 1'b1;
						new_q <= (count_q + 1'b1 >= FillW'(MedianMinCount)) & ~count_q[0];
					end
					state_q <= S_CHECK; i_q <= '0;
				end
				S_CHECK: begin
					// entry after the write: decide whether a median is due
					if (new_q) begin updated_q <= 1'b1; state_q <= S_OUTER; end
					else state_q <= S_DONE;
				end
				S_OUTER: begin
					// read of slot i issued this cycle; j scan starts next
					j_q <= '0; lt_q <= '0; le_q <= '0; state_q <= S_INNER; new_q <= 1'b1;
				end
				S_INNER: begin
					if (new_q) begin
						cand_q <= rd_val; new_q <= 1'b0;
						j_q <= j_q; // first cycle captures candidate, read j=0 now
					end else begin
						if ($signed(rd_val) < $signed(cand_q)) lt_q <= lt_q + 1'b1;
						if ($signed(rd_val) <= $signed(cand_q)) le_q <= le_q + 1'b1;
						if (j_q == count_q - 1'b1) begin
							if (lt_q + ($signed(rd_val) < $signed(cand_q)) <= (count_q >> 1) &&
							    (count_q >> 1) < le_q + ($signed(rd_val) <= $signed(cand_q))) begin
								offset_q <= (mag <= {2'b0, limit_q}) ? cand_q : '0;
								state_q <= S_DONE;
							end else begin
								i_q <= i_q + 1'b1; state_q <= S_OUTER;
							end
						end else j_q <= j_q + 1'b1;
					end
				end
				S_DONE: begin m_tvalid <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= FillW'(1) && count_q <= WinFull) else $error("window fill out of range");
	a_peer_quota: assert property (@(posedge clk) disable iff (!arst_n)
		peers_q <= WinFull) else $error("peer count beyond quota");
	a_upd_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (taken_q || !updated_q)) else $error("median without taken sample");
`endif
endmodule
